// File: hdl/ccsm_pkg.sv
// Shared types and constants of the clock cache slot manager.
package ccsm_pkg;

  localparam int unsigned SlotsDefault  = 64;
  localparam int unsigned LevelsDefault = 4;
  localparam int unsigned NumFloors     = 4;
  localparam int unsigned KeyW          = 51;
  localparam int unsigned FloorW        = 6;
  localparam int unsigned GenW          = 16;
  localparam int unsigned SlotOutW      = 6;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [1:0] ModeLookup = 2'd0;
  localparam logic [1:0] ModeProbe  = 2'd1;
  localparam logic [1:0] ModeInsert = 2'd2;
  localparam logic [1:0] ModeClear  = 2'd3;

  localparam logic [2:0] StHit   = 3'd0;
  localparam logic [2:0] StMiss  = 3'd1;
  localparam logic [2:0] StFree  = 3'd2;
  localparam logic [2:0] StEvict = 3'd3;
  localparam logic [2:0] StStale = 3'd4;
  localparam logic [2:0] StClear = 3'd5;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]      mode;
    logic [KeyW-1:0] key;
    logic [GenW-1:0] tag;
  } cmd_t;

endpackage

// File: hdl/ccsm_ram.sv
// Generic single-port RAM with a registered read.
module ccsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: hdl/ccsm_front.sv
// Front end: accepts items, packs the key and holds them in a short queue.
module ccsm_front import ccsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  block_level_i,
  input  logic [15:0] block_z_i,
  input  logic [15:0] block_y_i,
  input  logic [15:0] block_x_i,
  input  logic [15:0] generation_tag_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_take_i
);

  cmd_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q].mode <= mode_i;
      buf_q[wr_q].key  <= {block_level_i, block_z_i, block_y_i, block_x_i};
      buf_q[wr_q].tag  <= generation_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (cmd_take_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take_i};
    end
  end

endmodule

// File: hdl/ccsm_back.sv
// Back end: key search, free-slot scan, clock sweep and clear over the slot store.
module ccsm_back import ccsm_pkg::*; #(
  parameter int unsigned Slots  = SlotsDefault,
  parameter int unsigned Levels = LevelsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   cmd_take_o,
  input  logic [FloorW-1:0]      floor_i [NumFloors],
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [SlotOutW-1:0]    slot_index_o,
  output logic [GenW-1:0]        current_generation_o
);

  localparam int unsigned SW   = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned LvW  = (Levels > 1) ? $clog2(Levels) : 1;
  localparam logic [SW-1:0] LastSlot = SW'(Slots - 1);
  localparam logic [SW+1:0] SweepMax = (SW + 2)'(2 * Slots);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SFind   = 3'd1;
  localparam logic [2:0] SFree   = 3'd2;
  localparam logic [2:0] SSweep  = 3'd3;
  localparam logic [2:0] SWrite  = 3'd4;
  localparam logic [2:0] SOut    = 3'd5;
  localparam logic [2:0] SClear  = 3'd6;

  logic [2:0]       state_q;
  cmd_t             cmd_q;
  logic [SW-1:0]    idx_q, hand_q, slot_q;
  logic             rd_ok_q;
  logic [SW-1:0]    rd_idx_q;
  logic [SW+1:0]    n_q;
  logic [Slots-1:0] occ_q, used_q;
  logic [CntW-1:0]  occ_cnt_q;
  logic [6:0]       lvl_cnt_q [Levels];
  logic [GenW-1:0]  gen_q;
  logic [2:0]       st_q;

  // Key RAM, read address follows idx_q; the registered data is for the idx of the previous cycle.
  logic             ram_we;
  logic [SW-1:0]    ram_addr;
  logic [KeyW-1:0]  ram_rdata;

  ccsm_ram #(.Width(KeyW), .Depth(Slots)) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cmd_q.key),
    .rdata_o (ram_rdata)
  );

  assign ram_we   = (state_q == SWrite);
  assign ram_addr = (state_q == SWrite) ? slot_q : idx_q;

  logic [SW-1:0] idx_nx;
  assign idx_nx = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;

  // Protection of the slot whose key was just read.
  logic [2:0] rd_lvl;
  logic       rd_prot;
  always_comb begin
    rd_lvl  = ram_rdata[KeyW-1 -: 3];
    rd_prot = 1'b0;
    if (32'(rd_lvl) < Levels) begin
      rd_prot = ({1'b0, lvl_cnt_q[LvW'(rd_lvl)]} <=
                 ((32'(rd_lvl) < NumFloors) ? 8'(floor_i[rd_lvl[1:0]]) : 8'd0));
    end
  end

  logic [2:0] new_lvl;
  assign new_lvl    = cmd_q.key[KeyW-1 -: 3];
  assign cmd_take_o = (state_q == SIdle) && cmd_valid_i;

  assign out_valid_o          = (state_q == SOut);
  assign status_o             = st_q;
  assign current_generation_o = gen_q;
  always_comb begin
    slot_index_o = '0;
    if (st_q != StMiss && st_q != StStale && st_q != StClear) begin
      slot_index_o = SlotOutW'({{SlotOutW{1'b0}}, slot_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      idx_q     <= '0;
      hand_q    <= '0;
      slot_q    <= '0;
      rd_ok_q   <= 1'b0;
      rd_idx_q  <= '0;
      n_q       <= '0;
      occ_q     <= '0;
      used_q    <= '0;
      occ_cnt_q <= '0;
      gen_q     <= '0;
      st_q      <= StHit;
      for (int l = 0; l < Levels; l++) lvl_cnt_q[l] <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (cmd_take_o) begin
            idx_q   <= '0;
            rd_ok_q <= 1'b0;
            if (cmd_i.mode == ModeClear) begin
              state_q <= SClear;
            end else if (cmd_i.mode == ModeInsert && cmd_i.tag != gen_q) begin
              st_q    <= StStale;
              state_q <= SOut;
            end else begin
              state_q <= SFind;
            end
          end
        end
        SFind: begin
          // Linear search: one key read per cycle.
          rd_ok_q  <= 1'b1;
          rd_idx_q <= idx_q;
          idx_q    <= idx_nx;
          if (rd_ok_q && occ_q[rd_idx_q] && ram_rdata == cmd_q.key) begin
            slot_q  <= rd_idx_q;
            st_q    <= StHit;
            state_q <= SOut;
            if (cmd_q.mode != ModeProbe) used_q[rd_idx_q] <= 1'b1;
          end else if (rd_ok_q && rd_idx_q == LastSlot) begin
            if (cmd_q.mode != ModeInsert) begin
              st_q    <= StMiss;
              state_q <= SOut;
            end else if (32'(occ_cnt_q) < Slots) begin
              idx_q   <= hand_q;
              state_q <= SFree;
            end else begin
              idx_q   <= hand_q;
              rd_ok_q <= 1'b0;
              n_q     <= '0;
              state_q <= SSweep;
            end
          end
        end
        SFree: begin
          // Occupancy bits are flops, so the scan needs no RAM read.
          idx_q <= idx_nx;
          if (!occ_q[idx_q]) begin
            slot_q           <= idx_q;
            hand_q           <= idx_nx;
            occ_q[idx_q]     <= 1'b1;
            occ_cnt_q        <= occ_cnt_q + 1'b1;
            st_q             <= StFree;
            state_q          <= SWrite;
          end
        end
        SSweep: begin
          // Read of slot idx_q issued; decision on rd_idx_q follows in the next cycle.
          rd_ok_q  <= 1'b1;
          rd_idx_q <= idx_q;
          idx_q    <= idx_nx;
          if (rd_ok_q) begin
            hand_q <= (rd_idx_q == LastSlot) ? '0 : rd_idx_q + 1'b1;
            n_q    <= n_q + 1'b1;
            if (n_q == SweepMax || (!rd_prot && !used_q[rd_idx_q])) begin
              slot_q  <= rd_idx_q;
              st_q    <= StEvict;
              state_q <= SWrite;
              if (32'(rd_lvl) < Levels && lvl_cnt_q[LvW'(rd_lvl)] != '0) begin
                lvl_cnt_q[LvW'(rd_lvl)] <= lvl_cnt_q[LvW'(rd_lvl)] - 1'b1;
              end
            end else if (!rd_prot) begin
              used_q[rd_idx_q] <= 1'b0;
            end
          end
        end
        SWrite: begin
          used_q[slot_q] <= 1'b1;
          if (32'(new_lvl) < Levels) begin
            lvl_cnt_q[LvW'(new_lvl)] <= lvl_cnt_q[LvW'(new_lvl)] + 1'b1;
          end
          state_q <= SOut;
        end
        SClear: begin
          occ_q     <= '0;
          used_q    <= '0;
          occ_cnt_q <= '0;
          hand_q    <= '0;
          gen_q     <= gen_q + 1'b1;
          st_q      <= StClear;
          for (int l = 0; l < Levels; l++) lvl_cnt_q[l] <= '0;
          state_q   <= SOut;
        end
        SOut: begin
          if (!out_stall_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// File: hdl/clock_cache_slot_manager_core.sv
// Top level of the clock cache slot manager.
// The back end handles one item at a time; the linear key search over the key RAM
// (one read per cycle) and, for inserts, the free-slot scan or the clock sweep set
// its pace. A two-entry queue in the front end takes the next item meanwhile.
// Reset (rst_ni low, asynchronous) empties the cache, zeroes floors and generation.
module clock_cache_slot_manager_core import ccsm_pkg::*; #(
  parameter int unsigned Slots  = SlotsDefault,
  parameter int unsigned Levels = LevelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [FloorW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [2:0]          block_level_i,
  input  logic [15:0]         block_z_i,
  input  logic [15:0]         block_y_i,
  input  logic [15:0]         block_x_i,
  input  logic [15:0]         generation_tag_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [SlotOutW-1:0] slot_index_o,
  output logic [GenW-1:0]     current_generation_o
);

  // Floor registers: one per protected level.
  logic [FloorW-1:0] floor_q [NumFloors];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < NumFloors; f++) floor_q[f] <= '0;
    end else if (cfg_we_i) begin
      floor_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Front end accepts and packs the item; the queue decouples the back end.
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  ccsm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .block_level_i,
    .block_z_i, .block_y_i, .block_x_i, .generation_tag_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Back end carries each command out and holds its result until transfer.
  ccsm_back #(.Slots(Slots), .Levels(Levels)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .floor_i     (floor_q),
    .out_valid_o, .out_stall_i, .status_o, .slot_index_o, .current_generation_o
  );

endmodule

// File: hdl/ccsm_checker.sv
// Port-level checker for the clock cache slot manager, bound to the top level.
module ccsm_checker import ccsm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          status_o,
  input logic [SlotOutW-1:0] slot_index_o,
  input logic [GenW-1:0]     current_generation_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StClear)
    else $error("bad status");

  a_zero_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StMiss || status_o == StStale || status_o == StClear)
    |-> slot_index_o == '0)
    else $error("slot not zero");

  a_gen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(current_generation_o) |->
      current_generation_o == $past(current_generation_o) + 1'b1)
    else $error("generation jumped");

endmodule

bind clock_cache_slot_manager_core ccsm_checker u_ccsm_checker (.*);
